// ===== rtl/core/pbn_pkg.sv =====
// pbn_pkg: shared types and constants for the partial bell number block
// no dependencies; used by partial_bell_number_mod
package pbn_pkg;

	// default table size (largest n)
	localparam int MAX_N_DEF = 64;

	// register widths and reset values
	localparam int MAXN_W    = 7;
	localparam int MOD_W     = 31;
	localparam int VAL_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [MAXN_W-1:0] MAXN_RST   = 7'd64;
	localparam logic              MODON_RST  = 1'b1;
	localparam logic [MOD_W-1:0]  MOD_RST    = 31'd998244353;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_N      = 2'd0,
		CFG_MODULUS_ON = 2'd1,
		CFG_MODULUS    = 2'd2
	} cfg_idx_t;

	// status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_RANGE = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROW,
		ST_BRD,
		ST_BMUL,
		ST_BRED,
		ST_BWR,
		ST_QSTART,
		ST_QRD,
		ST_QDRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/pbn_ram.sv =====
// pbn_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
module pbn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4225
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/partial_bell_number_mod.sv =====
// partial_bell_number_mod: sums S(n,j) for j<=min(k,n), reduced or wrapped at 64 bits
// table build: runs once on the first request after reset or a config write; each entry reads one
// memory word, multiplies, reduces bit-serially over W steps (W = index width) and writes back
// query: reads and sums S(n,j) for j up to min(k,n), skipping the reads when n is out of range;
// one request at a time, and a stalled result holds off the next request
// reset clears control state and marks the table stale; registers take their reset values
// depends on pbn_pkg and pbn_ram
module partial_bell_number_mod #(
	parameter int MAX_N = pbn_pkg::MAX_N_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pbn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbn_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pbn_pkg::MAXN_W-1:0]      n,
	input  logic [pbn_pkg::MAXN_W-1:0]      k,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pbn_pkg::VAL_W-1:0]       bell_value,
	output logic                            status
);

	localparam int ROW   = MAX_N + 1;
	localparam int DEPTH = ROW * ROW;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_N + 1);
	localparam int VW    = pbn_pkg::VAL_W;
	localparam int MW    = pbn_pkg::MOD_W;
	localparam int NW    = pbn_pkg::MAXN_W;

	pbn_pkg::state_t state_q, state_d;

	logic [NW-1:0] max_n_q;
	logic          mod_on_q;
	logic [MW-1:0] modulus_q;
	logic          tbl_valid_q;

	logic [IW-1:0] lim_q, i_q, j_q, kk_q;
	logic [IW-1:0] step_q;
	logic [AW-1:0] base_prev_q, base_cur_q, qbase_q;
	logic [NW-1:0] n_q, k_q;
	logic [VW-1:0] diag_q, same_q, prod_q, sum_q;
	logic          rdv_s1;
	logic          out_valid_q, status_q;
	logic [VW-1:0] bell_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [VW-1:0] mem_wdata, mem_rdata;

	logic          use_mod;
	logic [VW-1:0] mod_ext, one_val, same_v, cand, bsum, bsum_r, qsum, qsum_r;
	logic [IW-1:0] lim_v;

	pbn_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// modulus handling
	assign use_mod = mod_on_q && (modulus_q != '0);
	assign mod_ext = {{(VW-MW){1'b0}}, modulus_q};
	assign one_val = (use_mod && modulus_q == MW'(1)) ? '0 : VW'(1);
	assign lim_v   = (32'(max_n_q) > 32'(MAX_N)) ? IW'(MAX_N) : IW'(max_n_q);

	// build datapath
	assign same_v = (j_q == i_q) ? '0 : mem_rdata;
	assign cand   = prod_q >= (mod_ext << step_q) ? prod_q - (mod_ext << step_q) : prod_q;
	assign bsum   = diag_q + prod_q;
	assign bsum_r = (use_mod && bsum >= mod_ext) ? bsum - mod_ext : bsum;

	// query accumulate
	assign qsum   = sum_q + mem_rdata;
	assign qsum_r = (use_mod && qsum >= mod_ext) ? qsum - mod_ext : qsum;

	// handshakes
	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == pbn_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign bell_value = bell_q;
	assign status     = status_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbn_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tbl_valid_q ? pbn_pkg::ST_QSTART : pbn_pkg::ST_INIT;
				end
			end
			pbn_pkg::ST_INIT: begin
				state_d = (lim_q == '0) ? pbn_pkg::ST_QSTART : pbn_pkg::ST_ROW;
			end
			pbn_pkg::ST_ROW:  state_d = pbn_pkg::ST_BRD;
			pbn_pkg::ST_BRD:  state_d = pbn_pkg::ST_BMUL;
			pbn_pkg::ST_BMUL: state_d = use_mod ? pbn_pkg::ST_BRED : pbn_pkg::ST_BWR;
			pbn_pkg::ST_BRED: begin
				if (step_q == '0) begin
					state_d = pbn_pkg::ST_BWR;
				end
			end
			pbn_pkg::ST_BWR: begin
				if (j_q != i_q) begin
					state_d = pbn_pkg::ST_BRD;
				end else if (i_q == lim_q) begin
					state_d = pbn_pkg::ST_QSTART;
				end else begin
					state_d = pbn_pkg::ST_ROW;
				end
			end
			pbn_pkg::ST_QSTART: begin
				state_d = (32'(n_q) > 32'(lim_q)) ? pbn_pkg::ST_DONE : pbn_pkg::ST_QRD;
			end
			pbn_pkg::ST_QRD: begin
				if (j_q == kk_q) begin
					state_d = pbn_pkg::ST_QDRAIN;
				end
			end
			pbn_pkg::ST_QDRAIN: state_d = pbn_pkg::ST_DONE;
			pbn_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = pbn_pkg::ST_IDLE;
				end
			end
			default: state_d = pbn_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = base_prev_q + AW'(j_q);
		case (state_q)
			pbn_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = one_val;
			end
			pbn_pkg::ST_ROW: begin
				mem_we    = 1'b1;
				mem_waddr = base_cur_q;
			end
			pbn_pkg::ST_BWR: begin
				mem_we    = 1'b1;
				mem_waddr = base_cur_q + AW'(j_q);
				mem_wdata = bsum_r;
			end
			pbn_pkg::ST_QRD: mem_raddr = qbase_q + AW'(j_q);
			default: mem_raddr = base_prev_q + AW'(j_q);
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers and table flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_n_q     <= pbn_pkg::MAXN_RST;
			mod_on_q    <= pbn_pkg::MODON_RST;
			modulus_q   <= pbn_pkg::MOD_RST;
			tbl_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pbn_pkg::CFG_MAX_N: begin
						max_n_q     <= cfg_data[NW-1:0];
						tbl_valid_q <= 1'b0;
					end
					pbn_pkg::CFG_MODULUS_ON: begin
						mod_on_q    <= cfg_data[0];
						tbl_valid_q <= 1'b0;
					end
					pbn_pkg::CFG_MODULUS: begin
						modulus_q   <= cfg_data[MW-1:0];
						tbl_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end else if (state_q == pbn_pkg::ST_QSTART) begin
				tbl_valid_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pbn_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pbn_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
			bell_q   <= sum_q;
			status_q <= (32'(n_q) > 32'(lim_q)) ? pbn_pkg::STAT_RANGE : pbn_pkg::STAT_OK;
		end
	end

	// read-valid flag for the query pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == pbn_pkg::ST_QRD);
		end
	end

	// build and query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pbn_pkg::ST_IDLE: begin
				n_q   <= n;
				k_q   <= k;
				lim_q <= lim_v;
			end
			pbn_pkg::ST_INIT: begin
				i_q         <= IW'(1);
				base_prev_q <= '0;
				base_cur_q  <= AW'(ROW);
			end
			pbn_pkg::ST_ROW: begin
				diag_q <= (i_q == IW'(1)) ? one_val : '0;
				j_q    <= IW'(1);
			end
			pbn_pkg::ST_BMUL: begin
				same_q <= same_v;
				prod_q <= same_v * VW'(j_q);
				step_q <= IW'(IW - 1);
			end
			pbn_pkg::ST_BRED: begin
				prod_q <= cand;
				step_q <= step_q - IW'(1);
			end
			pbn_pkg::ST_BWR: begin
				diag_q <= same_q;
				if (j_q != i_q) begin
					j_q <= j_q + IW'(1);
				end else begin
					i_q         <= i_q + IW'(1);
					base_prev_q <= base_cur_q;
					base_cur_q  <= base_cur_q + AW'(ROW);
				end
			end
			pbn_pkg::ST_QSTART: begin
				sum_q   <= '0;
				j_q     <= '0;
				kk_q    <= (k_q > n_q) ? IW'(n_q) : IW'(k_q);
				qbase_q <= AW'(IW'(n_q)) * AW'(ROW);
			end
			pbn_pkg::ST_QRD: begin
				j_q <= j_q + IW'(1);
				if (rdv_s1) begin
					sum_q <= qsum_r;
				end
			end
			pbn_pkg::ST_QDRAIN: begin
				if (rdv_s1) begin
					sum_q <= qsum_r;
				end
			end
			default: ;
		endcase
	end

	// no table writes while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pbn_pkg::ST_IDLE |-> !mem_we)
		else $error("table written while idle");

	// reduced entries stay below the modulus
	a_entry_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && use_mod && mem_waddr != '0) |-> mem_wdata < mod_ext)
		else $error("table entry not reduced");

	// range error results carry a zero value
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == pbn_pkg::STAT_RANGE) |-> bell_q == '0)
		else $error("range error with nonzero value");

endmodule
